// ----- hdl/dpd_pkg.sv -----
// Shared widths, register indexes and defaults for the detection proposal decoder.
package dpd_pkg;

  localparam int unsigned ELEM_W = 24;
  localparam int unsigned BOX_W = 16;
  localparam int unsigned CLASS_W = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned THR_W = 9;
  localparam int unsigned CFG_W = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned THR_FRAC = 8;

  localparam int unsigned DEF_MAX_CLASSES = 80;
  localparam int unsigned DEF_FRACTION_BITS = 8;

  localparam logic [COUNT_W-1:0] RST_CLASS_COUNT = 8'd80;
  localparam logic [THR_W-1:0] RST_SCORE_THRESHOLD = 9'd128;

  localparam logic [COUNT_W-1:0] POS_CENTER_X = 8'd0;
  localparam logic [COUNT_W-1:0] POS_CENTER_Y = 8'd1;
  localparam logic [COUNT_W-1:0] POS_WIDTH = 8'd2;
  localparam logic [COUNT_W-1:0] POS_HEIGHT = 8'd3;
  localparam logic [COUNT_W-1:0] POS_OBJECT = 8'd4;
  localparam logic [COUNT_W-1:0] POS_FIRST_CLASS = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASS_COUNT = 1'b0,
    CFG_SCORE_THRESHOLD = 1'b1
  } cfg_index_e;

  typedef logic signed [BOX_W-1:0] box_t;
  typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

// ----- hdl/dpd_to_int.sv -----
// Fixed-point to integer conversion with truncation toward zero and 16-bit saturation.
module dpd_to_int #(
  parameter int unsigned FRACTION_BITS = dpd_pkg::DEF_FRACTION_BITS
) (
  input  dpd_pkg::elem_t value_i,
  output dpd_pkg::box_t  int_o
);
  import dpd_pkg::*;

  localparam int unsigned W = ELEM_W + 1;

  logic signed [W-1:0] biased;
  logic signed [W-1:0] shifted;
  logic                overflow;

  assign biased = W'(value_i) + (value_i[ELEM_W-1] ? W'((1 << FRACTION_BITS) - 1) : W'(0));
  assign shifted = biased >>> FRACTION_BITS;
  assign overflow = (shifted[W-1:BOX_W-1] != '0) && (shifted[W-1:BOX_W-1] != '1);

  always_comb begin
    if (overflow) begin
      int_o = shifted[W-1] ? box_t'({1'b1, {(BOX_W-1){1'b0}}}) : box_t'({1'b0, {(BOX_W-1){1'b1}}});
    end else begin
      int_o = box_t'(shifted[BOX_W-1:0]);
    end
  end

endmodule

// ----- hdl/dpd_corner.sv -----
// Corner coordinate from an integer center and size, with 16-bit saturation.
module dpd_corner (
  input  dpd_pkg::box_t center_i,
  input  dpd_pkg::box_t size_i,
  output dpd_pkg::box_t corner_o
);
  import dpd_pkg::*;

  logic signed [BOX_W:0]   size_ext;
  logic signed [BOX_W:0]   half;
  logic signed [BOX_W+1:0] diff;
  logic                    overflow;

  assign size_ext = (BOX_W+1)'(size_i) + (BOX_W+1)'({1'b0, size_i[BOX_W-1]});
  assign half = size_ext >>> 1;
  assign diff = (BOX_W+2)'(center_i) - (BOX_W+2)'(half);
  assign overflow = (diff[BOX_W+1:BOX_W-1] != '0) && (diff[BOX_W+1:BOX_W-1] != '1);

  always_comb begin
    if (overflow) begin
      corner_o = diff[BOX_W+1] ? box_t'({1'b1, {(BOX_W-1){1'b0}}}) :
                                 box_t'({1'b0, {(BOX_W-1){1'b1}}});
    end else begin
      corner_o = box_t'(diff[BOX_W-1:0]);
    end
  end

endmodule

// ----- hdl/detection_proposal_decode.sv -----
// Top level of the detection proposal decoder.
// The block takes one row element per cycle with no gaps needed between rows. Every
// element updates the row registers in the cycle it is transferred, and a kept row's result
// appears in the output register in the cycle after the row's last element. in_ready_o drops only
// while a result waits to be taken and the next element would end a row; all other elements
// keep flowing into the row registers.
module detection_proposal_decode #(
  parameter int unsigned MAX_CLASSES = dpd_pkg::DEF_MAX_CLASSES,
  parameter int unsigned FRACTION_BITS = dpd_pkg::DEF_FRACTION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dpd_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [dpd_pkg::ELEM_W-1:0] element_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [dpd_pkg::BOX_W-1:0] corner_x_o,
  output logic signed [dpd_pkg::BOX_W-1:0] corner_y_o,
  output logic signed [dpd_pkg::BOX_W-1:0] box_width_o,
  output logic signed [dpd_pkg::BOX_W-1:0] box_height_o,
  output logic signed [dpd_pkg::ELEM_W-1:0] objectness_o,
  output logic [dpd_pkg::CLASS_W-1:0]     best_class_o,
  output logic                            class_found_o
);
  import dpd_pkg::*;

  localparam int unsigned CMP_W = ELEM_W + THR_W + FRACTION_BITS + 2;
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CLASSES);

  logic [COUNT_W-1:0] class_count_q;
  logic [THR_W-1:0]   threshold_q;

  logic [COUNT_W-1:0] pos_q, pos_d;
  box_t               cx_q, cx_d, cy_q, cy_d, w_q, w_d, h_q, h_d;
  elem_t              obj_q, obj_d, best_q, best_d;
  logic [CLASS_W-1:0] idx_q, idx_d;
  logic               found_q, found_d;

  logic                   out_valid_q;
  box_t                   corner_x_q, corner_y_q, box_width_q, box_height_q;
  elem_t                  objectness_q;
  logic [CLASS_W-1:0]     best_class_q;
  logic                   class_found_q;

  logic [COUNT_W-1:0] count_eff;
  logic [COUNT_W-1:0] last_pos;
  logic               is_last;
  logic               accept;
  logic               keep;
  box_t               conv;
  box_t               corner_x_c, corner_y_c;
  logic signed [CMP_W-1:0] lhs, rhs;

  assign count_eff = (class_count_q > MAX_COUNT) ? MAX_COUNT : class_count_q;
  assign last_pos = count_eff + POS_OBJECT;
  assign is_last = pos_q >= last_pos;
  assign in_ready_o = !out_valid_q || out_ready_i || !is_last;
  assign accept = in_valid_i && in_ready_o;

  dpd_to_int #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_to_int (
    .value_i(element_value_i),
    .int_o  (conv)
  );

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    w_d = w_q;
    h_d = h_q;
    obj_d = obj_q;
    best_d = best_q;
    idx_d = idx_q;
    found_d = found_q;
    unique case (pos_q)
      POS_CENTER_X: cx_d = conv;
      POS_CENTER_Y: cy_d = conv;
      POS_WIDTH: w_d = conv;
      POS_HEIGHT: h_d = conv;
      POS_OBJECT: obj_d = element_value_i;
      default: begin
        if (element_value_i > best_q) begin
          best_d = element_value_i;
          idx_d = CLASS_W'(pos_q - POS_FIRST_CLASS);
          found_d = 1'b1;
        end
      end
    endcase
    pos_d = pos_q + COUNT_W'(1);
  end

  dpd_corner u_corner_x (
    .center_i(cx_d),
    .size_i  (w_d),
    .corner_o(corner_x_c)
  );

  dpd_corner u_corner_y (
    .center_i(cy_d),
    .size_i  (h_d),
    .corner_o(corner_y_c)
  );

  assign lhs = CMP_W'(obj_d) <<< THR_FRAC;
  assign rhs = CMP_W'(threshold_q) << FRACTION_BITS;
  assign keep = lhs > rhs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= RST_CLASS_COUNT;
      threshold_q <= RST_SCORE_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_CLASS_COUNT: class_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_SCORE_THRESHOLD: threshold_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
      w_q <= '0;
      h_q <= '0;
      obj_q <= '0;
      best_q <= '0;
      idx_q <= '0;
      found_q <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        pos_q <= '0;
        cx_q <= '0;
        cy_q <= '0;
        w_q <= '0;
        h_q <= '0;
        obj_q <= '0;
        best_q <= '0;
        idx_q <= '0;
        found_q <= 1'b0;
      end else begin
        pos_q <= pos_d;
        cx_q <= cx_d;
        cy_q <= cy_d;
        w_q <= w_d;
        h_q <= h_d;
        obj_q <= obj_d;
        best_q <= best_d;
        idx_q <= idx_d;
        found_q <= found_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && is_last) begin
      out_valid_q <= keep;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_last) begin
      corner_x_q <= corner_x_c;
      corner_y_q <= corner_y_c;
      box_width_q <= w_d;
      box_height_q <= h_d;
      objectness_q <= obj_d;
      best_class_q <= found_d ? idx_d : '0;
      class_found_q <= found_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign corner_x_o = corner_x_q;
  assign corner_y_o = corner_y_q;
  assign box_width_o = box_width_q;
  assign box_height_o = box_height_q;
  assign objectness_o = objectness_q;
  assign best_class_o = best_class_q;
  assign class_found_o = class_found_q;

endmodule

// ----- hdl/dpd_checker.sv -----
// Port-level assertions for the detection proposal decoder and their binding.
module dpd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [dpd_pkg::BOX_W-1:0]  corner_x_o,
  input logic signed [dpd_pkg::BOX_W-1:0]  corner_y_o,
  input logic signed [dpd_pkg::BOX_W-1:0]  box_width_o,
  input logic signed [dpd_pkg::BOX_W-1:0]  box_height_o,
  input logic signed [dpd_pkg::ELEM_W-1:0] objectness_o,
  input logic [dpd_pkg::CLASS_W-1:0]       best_class_o,
  input logic                              class_found_o
);
  import dpd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(corner_x_o) &&
    $stable(corner_y_o) && $stable(box_width_o) && $stable(box_height_o) &&
    $stable(objectness_o) && $stable(best_class_o) && $stable(class_found_o))
    else $error("Result changed while its transfer was stalled.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input stalled with an empty output register.");

  a_no_class_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !class_found_o |-> best_class_o == '0)
    else $error("Class index set without a positive score.");

  a_obj_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> objectness_o > 0)
    else $error("Kept row with objectness not above the threshold.");

endmodule

bind detection_proposal_decode dpd_checker u_dpd_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the detection proposal decoder, with a directed table and random rows.
module testbench;
  import dpd_pkg::*;

  localparam int CLOCK_HALF = 4;
  localparam int PIXEL_SCALE = 1 << DEF_FRACTION_BITS;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam elem_t ELEM_MAX = 24'sh7fffff;
  localparam elem_t ELEM_MIN = 24'sh800000;

  typedef struct packed {
    box_t corner_x;
    box_t corner_y;
    box_t box_width;
    box_t box_height;
    elem_t objectness;
    logic [CLASS_W-1:0] best_class;
    logic class_found;
  } detection_t;

  typedef enum logic {STEP_ELEMENT, STEP_CONFIG} step_kind_e;

  typedef struct {
    step_kind_e kind;
    elem_t value;
    logic [CFG_W-1:0] count;
    logic [CFG_W-1:0] thr;
    bit typed;
    bit typed_kept;
    detection_t typed_det;
  } directed_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  elem_t element_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  box_t corner_x_o;
  box_t corner_y_o;
  box_t box_width_o;
  box_t box_height_o;
  elem_t objectness_o;
  logic [CLASS_W-1:0] best_class_o;
  logic class_found_o;

  detection_proposal_decode i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .element_value_i(element_value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .corner_x_o(corner_x_o),
    .corner_y_o(corner_y_o),
    .box_width_o(box_width_o),
    .box_height_o(box_height_o),
    .objectness_o(objectness_o),
    .best_class_o(best_class_o),
    .class_found_o(class_found_o)
  );

  int unsigned count_cfg = RST_CLASS_COUNT;
  int unsigned thr_cfg = RST_SCORE_THRESHOLD;
  int unsigned row_pos = 0;
  int center_x_px = 0;
  int center_y_px = 0;
  int width_px = 0;
  int height_px = 0;
  int object_q = 0;
  int best_q = 0;
  int unsigned best_idx = 0;
  bit class_seen = 1'b0;

  detection_t pending_detections[$];
  directed_step_t directed_steps[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit typed_check = 1'b0;
  bit typed_kept = 1'b0;
  detection_t typed_det = '0;

  logic [CFG_W-1:0] phase_count [PHASES] =
    '{9'd3, 9'd1, 9'h1ff, 9'd0, 9'd5, 9'd81, 9'd2, 9'd12};
  logic [CFG_W-1:0] phase_thr [PHASES] =
    '{9'd0, 9'd256, 9'd511, 9'd128, 9'd64, 9'd1, 9'd300, 9'd128};
  int sender_pct_of [4] = '{0, 50, 0, 24};
  int receiver_pct_of [4] = '{0, 0, 50, 24};

  always #CLOCK_HALF clk_i = ~clk_i;

  function automatic int clamp_box(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic bit decode_element(input elem_t v, output detection_t det);
    int val;
    int unsigned classes;
    bit kept;
    val = v;
    classes = (count_cfg > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : count_cfg;
    det = '0;
    kept = 1'b0;
    case (row_pos)
      POS_CENTER_X: center_x_px = clamp_box(val / PIXEL_SCALE);
      POS_CENTER_Y: center_y_px = clamp_box(val / PIXEL_SCALE);
      POS_WIDTH: width_px = clamp_box(val / PIXEL_SCALE);
      POS_HEIGHT: height_px = clamp_box(val / PIXEL_SCALE);
      POS_OBJECT: object_q = val;
      default: begin
        if (val > best_q) begin
          best_q = val;
          best_idx = row_pos - POS_FIRST_CLASS;
          class_seen = 1'b1;
        end
      end
    endcase
    if (row_pos < classes + POS_OBJECT) begin
      row_pos++;
      return 1'b0;
    end
    if (longint'(object_q) * (1 << THR_FRAC) > longint'(thr_cfg) * PIXEL_SCALE) begin
      kept = 1'b1;
      det.corner_x = box_t'(clamp_box(center_x_px - width_px / 2));
      det.corner_y = box_t'(clamp_box(center_y_px - height_px / 2));
      det.box_width = box_t'(width_px);
      det.box_height = box_t'(height_px);
      det.objectness = elem_t'(object_q);
      det.best_class = class_seen ? best_idx[CLASS_W-1:0] : '0;
      det.class_found = class_seen;
    end
    row_pos = 0;
    center_x_px = 0;
    center_y_px = 0;
    width_px = 0;
    height_px = 0;
    object_q = 0;
    best_q = 0;
    best_idx = 0;
    class_seen = 1'b0;
    return kept;
  endfunction

  // Mostly plausible rows: boxes of moderate size, objectness close to the threshold and
  // class scores drawn from a narrow set so that ties occur, with some full-range noise.
  function automatic elem_t random_element();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return elem_t'($urandom);
    if (row_pos <= POS_HEIGHT) begin
      if (pick < 70)
        return elem_t'((int'($urandom_range(4000)) - 2000) * 256 + int'($urandom_range(255)));
      if (pick < 85) return $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
      return elem_t'($urandom);
    end
    if (row_pos == POS_OBJECT) begin
      if (pick < 65) return elem_t'(int'(thr_cfg) + int'($urandom_range(6)) - 3);
      if (pick < 85) return elem_t'(int'($urandom_range(1023)) - 64);
      return elem_t'($urandom);
    end
    if (pick < 55) return elem_t'((int'($urandom_range(6)) - 2) * 64);
    if (pick < 85) return elem_t'(int'($urandom_range(2000)) - 1000);
    return elem_t'($urandom);
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch in %s at %0t: expected %0d, actual %0d", field, $time, want, got);
    end
  endtask

  task automatic add_element(input elem_t v);
    directed_step_t s;
    s = '{kind: STEP_ELEMENT, value: v, count: '0, thr: '0,
          typed: 1'b0, typed_kept: 1'b0, typed_det: '0};
    directed_steps.insert(directed_steps.size(), s);
  endtask

  task automatic add_checked(input elem_t v, input bit kept, input detection_t det);
    directed_step_t s;
    s = '{kind: STEP_ELEMENT, value: v, count: '0, thr: '0,
          typed: 1'b1, typed_kept: kept, typed_det: det};
    directed_steps.insert(directed_steps.size(), s);
  endtask

  task automatic add_config(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] thr);
    directed_step_t s;
    s = '{kind: STEP_CONFIG, value: '0, count: count, thr: thr,
          typed: 1'b0, typed_kept: 1'b0, typed_det: '0};
    directed_steps.insert(directed_steps.size(), s);
  endtask

  task automatic push_element(input elem_t v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_detections.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] thr);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_CLASS_COUNT;
    cfg_data_i <= count;
    @(negedge clk_i);
    cfg_index_i <= CFG_SCORE_THRESHOLD;
    cfg_data_i <= thr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    detection_t want;
    detection_t det;
    bit kept;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_detections.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected detection result at %0t", $time);
        end else begin
          want = pending_detections.pop_front();
          compare_field("corner_x", want.corner_x, corner_x_o);
          compare_field("corner_y", want.corner_y, corner_y_o);
          compare_field("box_width", want.box_width, box_width_o);
          compare_field("box_height", want.box_height, box_height_o);
          compare_field("objectness", want.objectness, objectness_o);
          compare_field("best_class", want.best_class, best_class_o);
          compare_field("class_found", want.class_found, class_found_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        kept = decode_element(element_value_i, det);
        if (typed_check) begin
          kept = typed_kept;
          det = typed_det;
          typed_check = 1'b0;
        end
        if (kept) pending_detections.insert(pending_detections.size(), det);
      end
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_CLASS_COUNT: count_cfg = cfg_data_i[COUNT_W-1:0];
          CFG_SCORE_THRESHOLD: thr_cfg = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extreme inputs saturate both corners, and the single class score is the maximum.
    add_config(9'd1, 9'd128);
    add_element(ELEM_MAX);
    add_element(ELEM_MIN);
    add_element(ELEM_MIN);
    add_element(ELEM_MAX);
    add_element(24'sd129);
    add_checked(ELEM_MAX, 1'b1, detection_t'{corner_x: 16'sh7fff, corner_y: 16'sh8000,
      box_width: 16'sh8000, box_height: 16'sh7fff, objectness: 24'sd129,
      best_class: 8'd0, class_found: 1'b1});
    // Negative values truncate toward zero. The class count drops to zero after the
    // objectness, so the next element ends the row as a class score.
    add_element(-24'sd257);
    add_element(24'sd255);
    add_element(24'sd768);
    add_element(-24'sd767);
    add_element(ELEM_MAX);
    add_config(9'd0, 9'd0);
    add_checked(-24'sd5, 1'b1, detection_t'{corner_x: -16'sd2, corner_y: 16'sd1,
      box_width: 16'sd3, box_height: -16'sd2, objectness: ELEM_MAX,
      best_class: 8'd0, class_found: 1'b0});
    // Without classes a row ends at its objectness, and a score equal to the threshold
    // is rejected.
    add_element(24'sd256);
    add_element(24'sd512);
    add_element(24'sd1024);
    add_element(-24'sd1);
    add_checked(24'sd0, 1'b0, '0);
    add_element(24'sd256);
    add_element(24'sd512);
    add_element(24'sd1024);
    add_element(-24'sd1);
    add_checked(24'sd1, 1'b1, detection_t'{corner_x: -16'sd1, corner_y: 16'sd2,
      box_width: 16'sd4, box_height: 16'sd0, objectness: 24'sd1,
      best_class: 8'd0, class_found: 1'b0});

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CONFIG) begin
        settle();
        configure(directed_steps[i].count, directed_steps[i].thr);
      end else begin
        typed_check = directed_steps[i].typed;
        typed_kept = directed_steps[i].typed_kept;
        typed_det = directed_steps[i].typed_det;
        push_element(directed_steps[i].value);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      configure(phase_count[ph], phase_thr[ph]);
      sender_idle_pct = sender_pct_of[ph % 4];
      receiver_stall_pct = receiver_pct_of[ph % 4];
      repeat (ITEMS_PER_PHASE) push_element(random_element());
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/dpd_pkg.sv
hdl/dpd_to_int.sv
hdl/dpd_corner.sv
hdl/detection_proposal_decode.sv
hdl/dpd_checker.sv
test/testbench.sv
